### hdl/multi_ultrasonic_nearest_ranger_core_defines.svh
// Assertion macros for the multi-sensor ultrasonic ranger.
// Depends on nothing; included by the files that carry assertions.
`ifndef MULTI_ULTRASONIC_NEAREST_RANGER_CORE_DEFINES_SVH
`define MULTI_ULTRASONIC_NEAREST_RANGER_CORE_DEFINES_SVH

// Implication checked at every rising edge of clk, off while reset is held.
`define MUNR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Plain condition checked at every rising edge of clk, off while reset is held.
`define MUNR_ASSERT_HOLD(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

### hdl/munr_pkg.sv
// Shared types, constants and helpers of the multi-sensor ultrasonic ranger.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package munr_pkg;

  localparam int CNT_W  = 20;
  localparam int DIST_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // 343 m/s over two ways, in 1/16 cm per microsecond, scaled by 2^16.
  localparam logic [14:0] DIST_SCALE = 15'd17985;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_TRIGGER_WIDTH   = 2'd0;
  localparam logic [1:0] REG_ECHO_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_SCAN_PERIOD     = 2'd2;
  localparam logic [1:0] REG_COLLISION_LIMIT = 2'd3;

  localparam logic [9:0]        RST_TRIGGER_WIDTH   = 10'd10;
  localparam logic [CNT_W-1:0]  RST_ECHO_TIMEOUT    = 20'd50000;
  localparam logic [CNT_W-1:0]  RST_SCAN_PERIOD     = 20'd200000;
  localparam logic [DIST_W-1:0] RST_COLLISION_LIMIT = 16'd320;

  typedef struct packed {
    logic       echo_level;
    logic [3:0] move_direction;
  } munr_in_t;

  typedef struct packed {
    logic [7:0]        trigger_lines;
    logic              sensor_done;
    logic [2:0]        sensor_number;
    logic [DIST_W-1:0] sensor_distance;
    logic              scan_done;
    logic [DIST_W-1:0] nearest_distance;
    logic [3:0]        nearest_sensor;
    logic              collision;
  } munr_out_t;

  typedef struct packed {
    logic [9:0]        trigger_width;
    logic [CNT_W-1:0]  echo_timeout;
    logic [CNT_W-1:0]  scan_period;
    logic [DIST_W-1:0] collision_limit;
  } munr_cfg_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

endpackage

### hdl/munr_dist.sv
// Echo width to distance conversion: one 20 x 15 bit multiply and saturation.
// Depends on munr_pkg.
`timescale 1ns / 1ps

module munr_dist
  import munr_pkg::*;
(
  input  logic [CNT_W-1:0]  echo_width,
  output logic [DIST_W-1:0] distance
);

  logic [CNT_W+14:0] product;
  logic [CNT_W-2:0]  scaled;

  assign product = {15'b0, echo_width} * {{CNT_W{1'b0}}, DIST_SCALE};
  assign scaled  = product[CNT_W+14:16];

  // Anything past 16 bits saturates to the largest distance.
  assign distance = (|scaled[CNT_W-2:DIST_W]) ? {DIST_W{1'b1}} : scaled[DIST_W-1:0];

endmodule

### hdl/munr_seq.sv
// Scan sequencer: phase machine, tick and echo counters and nearest tracking.
// Depends on munr_pkg and munr_dist.
`timescale 1ns / 1ps

module munr_seq
  import munr_pkg::*;
#(
  parameter int NUM_SENSORS = 3
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  munr_in_t  item,
  input  munr_cfg_t cfg,
  output munr_out_t result
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_RISE,
    PH_FALL
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  tick_r, tick_nxt;
  logic [2:0]        cur_r, cur_nxt;
  logic [CNT_W-1:0]  ew_r, ew_nxt;
  logic [DIST_W-1:0] best_dist_r, best_dist_nxt;
  logic [3:0]        best_sens_r, best_sens_nxt;
  logic              last_echo_r;

  logic [DIST_W-1:0] ew_dist;
  logic [CNT_W-1:0]  tick_inc;
  logic              finish;
  logic [DIST_W-1:0] fin_dist;
  logic              last_sensor;

  munr_dist u_dist (
    .echo_width (ew_r),
    .distance   (ew_dist)
  );

  assign tick_inc    = sat_inc(tick_r);
  assign last_sensor = ({1'b0, cur_r} + 4'd1) >= 4'(NUM_SENSORS);

  always_comb begin
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    cur_nxt       = cur_r;
    ew_nxt        = ew_r;
    best_dist_nxt = best_dist_r;
    best_sens_nxt = best_sens_r;
    finish        = 1'b0;
    fin_dist      = '0;
    result        = '0;

    unique case (phase_r)
      PH_IDLE: begin
        if (tick_r >= cfg.scan_period) begin
          phase_nxt     = PH_TRIG;
          tick_nxt      = '0;
          cur_nxt       = '0;
          best_dist_nxt = '0;
          best_sens_nxt = '0;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      PH_TRIG: begin
        result.trigger_lines = 8'b1 << cur_r;
        tick_nxt = tick_inc;
        if (tick_inc >= {10'b0, cfg.trigger_width}) begin
          phase_nxt = PH_RISE;
          tick_nxt  = '0;
          ew_nxt    = '0;
        end
      end
      PH_RISE: begin
        tick_nxt = tick_inc;
        if (item.echo_level && !last_echo_r) begin
          phase_nxt = PH_FALL;
          ew_nxt    = {{(CNT_W-1){1'b0}}, 1'b1};
        end else if (tick_inc >= cfg.echo_timeout) begin
          finish = 1'b1;
        end
      end
      PH_FALL: begin
        tick_nxt = tick_inc;
        if (!item.echo_level && last_echo_r) begin
          finish   = 1'b1;
          fin_dist = ew_dist;
        end else begin
          ew_nxt = sat_inc(ew_r);
          if (tick_inc >= cfg.echo_timeout) begin
            finish = 1'b1;
          end
        end
      end
    endcase

    if (finish) begin
      result.sensor_done     = 1'b1;
      result.sensor_number   = cur_r;
      result.sensor_distance = fin_dist;
      // A tie keeps the earlier sensor.
      if (fin_dist != '0 && (best_sens_r == '0 || fin_dist < best_dist_r)) begin
        best_dist_nxt = fin_dist;
        best_sens_nxt = {1'b0, cur_r} + 4'd1;
      end
      tick_nxt = '0;
      ew_nxt   = '0;
      if (last_sensor) begin
        result.scan_done        = 1'b1;
        result.nearest_distance = best_dist_nxt;
        result.nearest_sensor   = best_sens_nxt;
        result.collision        = (best_sens_nxt != '0) &&
                                  (best_dist_nxt < cfg.collision_limit) &&
                                  (best_sens_nxt == item.move_direction);
        phase_nxt = PH_IDLE;
      end else begin
        cur_nxt   = cur_r + 3'd1;
        phase_nxt = PH_TRIG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      cur_r       <= '0;
      ew_r        <= '0;
      best_dist_r <= '0;
      best_sens_r <= '0;
      last_echo_r <= 1'b0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      cur_r       <= cur_nxt;
      ew_r        <= ew_nxt;
      best_dist_r <= best_dist_nxt;
      best_sens_r <= best_sens_nxt;
      last_echo_r <= item.echo_level;
    end
  end

endmodule

### hdl/multi_ultrasonic_nearest_ranger_core.sv
// Top level of the multi-sensor ultrasonic ranger: ports, configuration
// registers, input register and result register. Depends on munr_pkg, munr_seq.
`timescale 1ns / 1ps
`include "multi_ultrasonic_nearest_ranger_core_defines.svh"

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    munr_in_t  (echo level, move direction)
// out_      output     out_valid / out_ready  munr_out_t (trigger lines, results)
// cfg_      input      cfg_we                 cfg_index, cfg_wdata
//
// Every accepted item (one microsecond tick) yields exactly one result item.
// An item waits in the input register, where the sequencer works on it, and
// its result lands in the result register; one item per cycle is sustained
// while in_valid and out_ready hold; the sequencer's next state is combinational.
// Reset is synchronous and active low; it clears the handshake flags, the
// sequencer state and loads the configuration defaults. A stalled result holds
// the input register, which in turn drops in_ready, so no item is lost.

module multi_ultrasonic_nearest_ranger_core
  import munr_pkg::*;
#(
  parameter int NUM_SENSORS = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  munr_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output munr_out_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_wdata
);

  munr_cfg_t cfg_r;
  logic      in_valid_r;
  munr_in_t  in_data_r;
  logic      out_valid_r;
  munr_out_t out_data_r;
  munr_out_t step_result;
  logic      advance;

  // The item in the input register moves on whenever the result register
  // is empty or being emptied in this cycle.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Configuration registers keep only their own widths.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_width   <= RST_TRIGGER_WIDTH;
      cfg_r.echo_timeout    <= RST_ECHO_TIMEOUT;
      cfg_r.scan_period     <= RST_SCAN_PERIOD;
      cfg_r.collision_limit <= RST_COLLISION_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRIGGER_WIDTH:   cfg_r.trigger_width   <= cfg_wdata[9:0];
        REG_ECHO_TIMEOUT:    cfg_r.echo_timeout    <= cfg_wdata;
        REG_SCAN_PERIOD:     cfg_r.scan_period     <= cfg_wdata;
        REG_COLLISION_LIMIT: cfg_r.collision_limit <= cfg_wdata[DIST_W-1:0];
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  munr_seq #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_data_r),
    .cfg     (cfg_r),
    .result  (step_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A finished scan always comes with the finish of its last sensor.
  `MUNR_ASSERT_IMPL(a_scan_has_sensor, out_valid_r && out_data_r.scan_done, out_data_r.sensor_done, "scan_done without sensor_done")
  // Scan results are only shown on the tick that ends the scan.
  `MUNR_ASSERT_IMPL(a_scan_fields_quiet, out_valid_r && !out_data_r.scan_done, out_data_r.nearest_sensor == 4'd0 && out_data_r.collision == 1'b0, "scan fields set outside scan end")
  // A collision needs an answering sensor.
  `MUNR_ASSERT_IMPL(a_collision_needs_sensor, out_valid_r && out_data_r.collision, out_data_r.nearest_sensor != 4'd0, "collision without nearest sensor")
  // At most one trigger line runs at a time.
  `MUNR_ASSERT_HOLD(a_one_trigger, !out_valid_r || $onehot0(out_data_r.trigger_lines), "several trigger lines high")

endmodule

### bench/tb_multi_ultrasonic_nearest_ranger_core.sv
// Self-checking testbench of the multi-sensor ultrasonic ranger core.
// Depends on munr_pkg and multi_ultrasonic_nearest_ranger_core; it needs no other file.
`timescale 1ns / 1ps

module tb_multi_ultrasonic_nearest_ranger_core
  import munr_pkg::*;
();

  localparam int NUM_SENSORS = 3;

  // Random ticks to send after the directed tests.
  localparam int RANDOM_TICKS = 250;

  // Cycles without any handshake before the run is declared hung. The longest
  // legal quiet stretch is a sender gap or a receiver stall.
  localparam int WATCHDOG_LIMIT = 4000;

  // 343 m/s over two ways, in 1/16 cm per tick, scaled by 2^16.
  localparam logic [35:0] SOUND_SCALE = 36'd17985;

  // Phases of the local ranger model.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TRIG,
    ST_RISE,
    ST_FALL
  } ranger_phase_e;

  // Shape of the echo that one sensor returns. The delay and length count
  // listen ticks. A pre-high echo is already up during the trigger pulse.
  typedef struct {
    bit          pre_high;
    int unsigned delay;
    int unsigned len;
  } echo_plan_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  munr_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  munr_out_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [CNT_W-1:0] cfg_wdata;

  multi_ultrasonic_nearest_ranger_core #(
    .NUM_SENSORS(NUM_SENSORS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Local model of the ranger. It is advanced once per accepted item and keeps
  // its own copy of the registers, so the expected result of every tick is
  // known the moment the tick is accepted.
  // ---------------------------------------------------------------------------
  munr_cfg_t     ranger_cfg;
  ranger_phase_e m_phase;
  logic [19:0]   m_ticks;
  logic [2:0]    m_sensor;
  logic [19:0]   m_width;
  logic [15:0]   m_best_range;
  logic [3:0]    m_best_sensor;
  logic          m_last_echo;
  int            scans_predicted;

  // Expected results, oldest first.
  munr_out_t predicted_readings[$];

  function automatic logic [19:0] count_up(input logic [19:0] v);
    return (v == 20'hFFFFF) ? v : v + 20'd1;
  endfunction

  // Echo width in ticks to distance in 1/16 cm, truncated and saturated.
  function automatic logic [15:0] to_sixteenths(input logic [19:0] w);
    logic [35:0] scaled;
    scaled = ({16'd0, w} * SOUND_SCALE) >> 16;
    return (scaled > 36'd65535) ? 16'hFFFF : scaled[15:0];
  endfunction

  function automatic munr_out_t advance_ranger(input munr_in_t tick);
    munr_out_t  r;
    logic       done_now;
    logic [15:0] range_val;
    r = '0;
    done_now = 1'b0;
    range_val = '0;
    case (m_phase)
      ST_IDLE: begin
        if (m_ticks >= ranger_cfg.scan_period) begin
          m_phase = ST_TRIG;
          m_ticks = '0;
          m_sensor = '0;
          m_best_range = '0;
          m_best_sensor = '0;
        end else begin
          m_ticks = count_up(m_ticks);
        end
      end
      ST_TRIG: begin
        // The trigger lines show the state at the start of the tick. A zero
        // trigger width still gives one tick of pulse.
        r.trigger_lines = 8'd1 << m_sensor;
        m_ticks = count_up(m_ticks);
        if (m_ticks >= {10'd0, ranger_cfg.trigger_width}) begin
          m_phase = ST_RISE;
          m_ticks = '0;
          m_width = '0;
        end
      end
      ST_RISE: begin
        m_ticks = count_up(m_ticks);
        // A rising edge wins over a timeout on the same tick.
        if (tick.echo_level && !m_last_echo) begin
          m_phase = ST_FALL;
          m_width = 20'd1;
        end else if (m_ticks >= ranger_cfg.echo_timeout) begin
          done_now = 1'b1;
        end
      end
      default: begin
        m_ticks = count_up(m_ticks);
        if (!tick.echo_level && m_last_echo) begin
          done_now = 1'b1;
          range_val = to_sixteenths(m_width);
        end else begin
          m_width = count_up(m_width);
          if (m_ticks >= ranger_cfg.echo_timeout) done_now = 1'b1;
        end
      end
    endcase

    if (done_now) begin
      r.sensor_done = 1'b1;
      r.sensor_number = m_sensor;
      r.sensor_distance = range_val;
      // Zero readings never count, and a tie keeps the earlier sensor.
      if (range_val != 0 && (m_best_sensor == 0 || range_val < m_best_range)) begin
        m_best_range = range_val;
        m_best_sensor = {1'b0, m_sensor} + 4'd1;
      end
      m_ticks = '0;
      m_width = '0;
      if (int'(m_sensor) + 1 >= NUM_SENSORS) begin
        r.scan_done = 1'b1;
        r.nearest_distance = m_best_range;
        r.nearest_sensor = m_best_sensor;
        r.collision = (m_best_sensor != 0 && m_best_range < ranger_cfg.collision_limit &&
                       m_best_sensor == tick.move_direction);
        m_phase = ST_IDLE;
        scans_predicted++;
      end else begin
        m_sensor = m_sensor + 3'd1;
        m_phase = ST_TRIG;
      end
    end
    m_last_echo = tick.echo_level;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Items go out in bursts of random length with random gaps between
  // them. Every call starts and ends at a falling edge; valid is lowered after
  // each acceptance and raised again in the same time step by the next call,
  // so the block never sees it drop between back-to-back items.
  // ---------------------------------------------------------------------------
  bit tx_gap_en;
  int burst_left;
  int ticks_sent;

  task automatic send_tick(input munr_in_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = tx_gap_en ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_data = item;
    do @(posedge clk); while (!in_ready);
    predicted_readings.push_back(advance_ranger(item));
    ticks_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Echo generator. It follows the local model's phase so that most ticks form
  // well-shaped measurements: a plan is picked when a sensor's trigger starts,
  // and the echo line follows it while that sensor listens. Directed tests queue
  // their own plans; otherwise they are random. Optional noise flips the line.
  // ---------------------------------------------------------------------------
  echo_plan_t  scripted_echoes[$];
  echo_plan_t  cur_plan;
  bit          plan_armed;
  int unsigned listen_idx;
  int          noise_pct;
  int          fixed_dir;

  function automatic echo_plan_t pick_plan();
    echo_plan_t p;
    int         r;
    if (scripted_echoes.size() != 0) return scripted_echoes.pop_front();
    r = $urandom_range(0, 99);
    p.pre_high = ($urandom_range(0, 9) == 0);
    p.delay = $urandom_range(0, 6);
    if (r < 15) p.len = 0;
    else if (r < 70) p.len = $urandom_range(1, 10);
    else if (r < 92) p.len = $urandom_range(10, 60);
    else p.len = $urandom_range(60, 200);
    return p;
  endfunction

  // Mostly a real sensor, sometimes none, sometimes a value that fits no sensor.
  function automatic logic [3:0] pick_dir();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return 4'($urandom_range(1, NUM_SENSORS));
    if (r < 16) return 4'd0;
    return 4'($urandom_range(NUM_SENSORS + 1, 15));
  endfunction

  task automatic drive_echo_tick();
    munr_in_t item;
    bit       listening;
    listening = (m_phase == ST_RISE || m_phase == ST_FALL);
    if (m_phase == ST_TRIG && !plan_armed) begin
      cur_plan = pick_plan();
      plan_armed = 1'b1;
      listen_idx = 0;
    end
    if (listening) begin
      plan_armed = 1'b0;
      if (cur_plan.pre_high) item.echo_level = (listen_idx < cur_plan.len);
      else item.echo_level = (listen_idx >= cur_plan.delay &&
                              listen_idx < cur_plan.delay + cur_plan.len);
      listen_idx++;
    end else if (m_phase == ST_TRIG) begin
      item.echo_level = cur_plan.pre_high;
    end else begin
      // The line is ignored while the block idles between scans.
      item.echo_level = $urandom_range(0, 1);
    end
    if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct) item.echo_level = ~item.echo_level;
    item.move_direction = (fixed_dir >= 0) ? 4'(fixed_dir) : pick_dir();
    send_tick(item);
  endtask

  task automatic run_ticks(input int n);
    repeat (n) drive_echo_tick();
  endtask

  task automatic run_scans(input int n);
    int target;
    target = scans_predicted + n;
    while (scans_predicted < target) drive_echo_tick();
  endtask

  // Holds the sender until every expected result has come back.
  task automatic wait_readings_drained();
    while (predicted_readings.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes one register at a falling edge. The local copy keeps only the
  // register's width, as the block does.
  task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_TRIGGER_WIDTH:   ranger_cfg.trigger_width = value[9:0];
      REG_ECHO_TIMEOUT:    ranger_cfg.echo_timeout = value;
      REG_SCAN_PERIOD:     ranger_cfg.scan_period = value;
      REG_COLLISION_LIMIT: ranger_cfg.collision_limit = value[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [CNT_W-1:0] trig, input logic [CNT_W-1:0] timeout,
                           input logic [CNT_W-1:0] period, input logic [CNT_W-1:0] limit);
    write_reg(REG_TRIGGER_WIDTH, trig);
    write_reg(REG_ECHO_TIMEOUT, timeout);
    write_reg(REG_SCAN_PERIOD, period);
    write_reg(REG_COLLISION_LIMIT, limit);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker. The receiver stalls in runs of random length; every
  // accepted result is compared field by field with the oldest expectation.
  // ---------------------------------------------------------------------------
  bit rx_stall_en;
  int stall_left;
  int fail_count;
  int results_seen;
  int scans_seen;
  int collisions_seen;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h", results_seen, what, got, want);
    fail_count++;
  endtask

  always @(negedge clk) begin
    if (!rx_stall_en) begin
      out_ready = 1'b1;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready = 1'b0;
      stall_left = $urandom_range(0, 7);
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    munr_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_readings.size() == 0) begin
        report_mismatch("result with no tick pending", 32'(out_data.sensor_done), 32'd0);
      end else begin
        want = predicted_readings.pop_front();
        if (out_data.trigger_lines !== want.trigger_lines)
          report_mismatch("trigger_lines", 32'(out_data.trigger_lines), 32'(want.trigger_lines));
        if (out_data.sensor_done !== want.sensor_done)
          report_mismatch("sensor_done", 32'(out_data.sensor_done), 32'(want.sensor_done));
        if (out_data.sensor_number !== want.sensor_number)
          report_mismatch("sensor_number", 32'(out_data.sensor_number), 32'(want.sensor_number));
        if (out_data.sensor_distance !== want.sensor_distance)
          report_mismatch("sensor_distance", 32'(out_data.sensor_distance),
                          32'(want.sensor_distance));
        if (out_data.scan_done !== want.scan_done)
          report_mismatch("scan_done", 32'(out_data.scan_done), 32'(want.scan_done));
        if (out_data.nearest_distance !== want.nearest_distance)
          report_mismatch("nearest_distance", 32'(out_data.nearest_distance),
                          32'(want.nearest_distance));
        if (out_data.nearest_sensor !== want.nearest_sensor)
          report_mismatch("nearest_sensor", 32'(out_data.nearest_sensor),
                          32'(want.nearest_sensor));
        if (out_data.collision !== want.collision)
          report_mismatch("collision", 32'(out_data.collision), 32'(want.collision));
        if (want.scan_done) scans_seen++;
        if (want.collision) collisions_seen++;
      end
      results_seen++;
    end
  end

  // Watchdog: a hung handshake on either side stops the run.
  int quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("** multi_ultrasonic_nearest_ranger_core: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Right after reset the scan period is long, so the block only idles.
  task automatic test_reset_values();
    tx_gap_en = 1'b1;
    rx_stall_en = 1'b1;
    run_ticks(6);
    wait_readings_drained();
  endtask

  // One clean scan: the first two sensors return the same distance, so the tie
  // must keep sensor 1, and the last sensor never answers. The motion faces
  // sensor 1, so a collision is flagged.
  task automatic test_basic_scan();
    echo_plan_t p;
    write_all(20'd2, 20'd12, 20'd1, 20'd65535);
    fixed_dir = 1;
    p = '{pre_high: 1'b0, delay: 2, len: 5};
    scripted_echoes.push_back(p);
    p = '{pre_high: 1'b0, delay: 0, len: 5};
    scripted_echoes.push_back(p);
    p = '{pre_high: 1'b0, delay: 0, len: 0};
    scripted_echoes.push_back(p);
    run_scans(1);
    fixed_dir = -1;
    wait_readings_drained();
  endtask

  // Zero trigger width, zero timeout, zero scan period and a zero limit. The
  // first sensor answers at once, the second stays silent and the third sees
  // an echo that is already high when listening starts. Two scans run back to
  // back, since a new scan follows one tick after the last.
  task automatic test_zero_settings();
    echo_plan_t p;
    write_all(20'd0, 20'd0, 20'd0, 20'd0);
    rx_stall_en = 1'b0;
    p = '{pre_high: 1'b0, delay: 0, len: 1};
    scripted_echoes.push_back(p);
    p = '{pre_high: 1'b0, delay: 0, len: 0};
    scripted_echoes.push_back(p);
    p = '{pre_high: 1'b1, delay: 0, len: 3};
    scripted_echoes.push_back(p);
    run_scans(2);
    rx_stall_en = 1'b1;
    wait_readings_drained();
  endtask

  // Writes with bits above the register width set; only the low bits count.
  task automatic test_register_masking();
    write_all(20'hFFC03, 20'd40, 20'd2, 20'hF0010);
    run_scans(1);
    wait_readings_drained();
  endtask

  // The longest scan period keeps the block idle for the whole test.
  task automatic test_scan_period_max();
    write_reg(REG_SCAN_PERIOD, 20'hFFFFF);
    run_ticks(12);
    wait_readings_drained();
  endtask

  // Longer trigger pulse and the longest timeout. The first sensor's echo is
  // long, the second is the nearest and faces the motion.
  // No idling on either side here, to keep the long measurement short in time.
  task automatic test_long_echo();
    echo_plan_t p;
    write_all(20'd12, 20'hFFFFF, 20'd0, 20'hFFFF);
    tx_gap_en = 1'b0;
    rx_stall_en = 1'b0;
    fixed_dir = 2;
    p = '{pre_high: 1'b0, delay: 1, len: 60};
    scripted_echoes.push_back(p);
    p = '{pre_high: 1'b0, delay: 0, len: 4};
    scripted_echoes.push_back(p);
    p = '{pre_high: 1'b0, delay: 2, len: 10};
    scripted_echoes.push_back(p);
    run_scans(1);
    fixed_dir = -1;
    tx_gap_en = 1'b1;
    rx_stall_en = 1'b1;
    wait_readings_drained();
  endtask

  // Random phases, each with its own register settings, idling mix and noise.
  // One phase holds the sender midway until every result is back.
  task automatic test_random_scans();
    int total;
    int phase_no;
    int phase_ticks;
    int r;
    total = 0;
    phase_no = 0;
    while (total < RANDOM_TICKS) begin
      r = $urandom_range(0, 3);
      write_reg(REG_TRIGGER_WIDTH, 20'($urandom_range(0, 6)));
      write_reg(REG_ECHO_TIMEOUT, (r == 0) ? 20'($urandom_range(0, 4))
                                           : 20'($urandom_range(10, 80)));
      write_reg(REG_SCAN_PERIOD, 20'($urandom_range(0, 10)));
      r = $urandom_range(0, 3);
      write_reg(REG_COLLISION_LIMIT, (r == 0) ? 20'd0 : (r == 1) ? 20'd65535
                                                     : 20'($urandom_range(1, 20)));
      tx_gap_en = ($urandom_range(0, 3) != 0);
      rx_stall_en = ($urandom_range(0, 3) != 0);
      noise_pct = ($urandom_range(0, 3) == 0) ? 8 : 0;
      phase_ticks = $urandom_range(60, 140);
      run_ticks(phase_ticks / 2);
      if (phase_no == 1) wait_readings_drained();
      run_ticks(phase_ticks - phase_ticks / 2);
      wait_readings_drained();
      total += phase_ticks;
      phase_no++;
    end
    noise_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_TRIGGER_WIDTH;
    cfg_wdata = '0;

    // Local model in its reset state.
    ranger_cfg.trigger_width = RST_TRIGGER_WIDTH;
    ranger_cfg.echo_timeout = RST_ECHO_TIMEOUT;
    ranger_cfg.scan_period = RST_SCAN_PERIOD;
    ranger_cfg.collision_limit = RST_COLLISION_LIMIT;
    m_phase = ST_IDLE;
    m_ticks = '0;
    m_sensor = '0;
    m_width = '0;
    m_best_range = '0;
    m_best_sensor = '0;
    m_last_echo = 1'b0;
    scans_predicted = 0;

    tx_gap_en = 1'b1;
    rx_stall_en = 1'b1;
    burst_left = 0;
    stall_left = 0;
    noise_pct = 0;
    fixed_dir = -1;
    plan_armed = 1'b0;
    listen_idx = 0;
    ticks_sent = 0;
    fail_count = 0;
    results_seen = 0;
    scans_seen = 0;
    collisions_seen = 0;
    quiet_cycles = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_basic_scan();
    test_zero_settings();
    test_register_masking();
    test_scan_period_max();
    test_long_echo();
    test_random_scans();

    // Let the pipeline settle before closing the books.
    wait_readings_drained();
    repeat (6) @(posedge clk);
    if (predicted_readings.size() != 0)
      report_mismatch("results never delivered", 32'(predicted_readings.size()), 32'd0);

    $display("Run covered %0d ticks and %0d finished scans, %0d with a collision warning,",
             ticks_sent, scans_seen, collisions_seen);
    $display("including zero and full-range settings, ties, silent sensors and long echoes.");
    if (fail_count == 0) begin
      $display("** multi_ultrasonic_nearest_ranger_core: PASSED **");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("** multi_ultrasonic_nearest_ranger_core: FAILED **");
    end
    $finish;
  end

endmodule
